FILE: rtl/core/btf_pkg.sv
// ----------------------------------------------------------------------------
// btf_pkg
// Shared types and constants of the background tile fetcher.
// ----------------------------------------------------------------------------
package btf_pkg;

   // Tiles fetched on one line before line_done is flagged (1..32).
   localparam int unsigned TILES_PER_LINE = 20;

   localparam int unsigned COL_W       = 5;
   localparam int unsigned CSR_IDX_W   = 3;
   localparam int unsigned CSR_DATA_W  = 8;
   localparam int unsigned REQ_DATA_W  = 32;
   localparam int unsigned RSP_DATA_W  = 40;
   localparam int unsigned RSP_USER_W  = 2;

   localparam logic [15:0] MAP_HI_BASE   = 16'h9C00;
   localparam logic [15:0] MAP_LO_BASE   = 16'h9800;
   localparam logic [15:0] DATA_U_BASE   = 16'h8000;
   localparam logic [15:0] DATA_S_BASE   = 16'h9000;

   // lcd_control bit positions
   localparam int unsigned LCDC_BG_EN    = 0;
   localparam int unsigned LCDC_BG_MAP   = 3;
   localparam int unsigned LCDC_DATA_SEL = 4;
   localparam int unsigned LCDC_WIN_EN   = 5;
   localparam int unsigned LCDC_WIN_MAP  = 6;

   localparam logic [7:0] LCDC_RESET     = 8'h91;
   localparam logic [7:0] BGP_RESET      = 8'hFC;

   typedef enum logic [1:0] {
      STEP_MAP  = 2'd0,
      STEP_LOW  = 2'd1,
      STEP_HIGH = 2'd2,
      STEP_PUSH = 2'd3
   } fetch_step_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LCD_CONTROL = 3'd0,
      CSR_SCROLL_X    = 3'd1,
      CSR_SCROLL_Y    = 3'd2,
      CSR_WINDOW_Y    = 3'd3,
      CSR_BG_PALETTE  = 3'd4
   } csr_index_type;

endpackage

FILE: rtl/core/background_tile_fetcher.sv
// ----------------------------------------------------------------------------
// background_tile_fetcher
// Background/window pixel fetcher: one beat in is one fetcher step unless sprite_busy
// holds it; one beat out carries the step's video memory read request or pixel push, if any.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (low bit up)                          | tuser / tlast
//  req_     | in  | vram_byte[7:0] line_y[15:8] window_line[23:16] | -
//           |     | fifo_empty[24] sprite_busy[25] zero[31:26]   |
//  rsp_     | out | read_addr[15:0] pixel_row[31:16]             | tuser: read_valid[0]
//           |     | pixel_palette[39:32]                         | push_valid[1]; tlast: line_done
//  csr_     | in  | csr_we, csr_index[2:0], csr_wdata[7:0]       | -
//
// One step per cycle while rsp is not stalled and sprite_busy is low: a req beat is decoded in
// the same cycle it is taken and its result lands in the rsp output register on that edge.
// req_tready is high whenever the output register is empty or being drained,
// so a stalled rsp side holds one result and back-pressures req.
// Reset (synchronous, active high) returns to the tile-map step at column
// zero with no outstanding read and the control registers at their defaults.
// ----------------------------------------------------------------------------
module background_tile_fetcher
   import btf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // vram_byte, line_y, window_line, fifo_empty, sprite_busy, zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // read_addr, pixel_row, pixel_palette
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // read_valid, push_valid
   output logic [RSP_USER_W-1:0] rsp_tuser,
   output logic                  rsp_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // ---- control registers ----
   logic [7:0] lcd_control_ff, scroll_x_ff, scroll_y_ff, window_y_ff, bg_palette_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lcd_control_ff <= LCDC_RESET;
         scroll_x_ff    <= '0;
         scroll_y_ff    <= '0;
         window_y_ff    <= '0;
         bg_palette_ff  <= BGP_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LCD_CONTROL: lcd_control_ff <= csr_wdata;
            CSR_SCROLL_X:    scroll_x_ff    <= csr_wdata;
            CSR_SCROLL_Y:    scroll_y_ff    <= csr_wdata;
            CSR_WINDOW_Y:    window_y_ff    <= csr_wdata;
            CSR_BG_PALETTE:  bg_palette_ff  <= csr_wdata;
            default: ;  // unmapped index: drop the write
         endcase
      end
   end

   // ---- request fields ----
   logic [7:0] vram_byte, line_y, window_line;
   logic       fifo_empty, sprite_busy;

   assign vram_byte   = req_tdata[7:0];
   assign line_y      = req_tdata[15:8];
   assign window_line = req_tdata[23:16];
   assign fifo_empty  = req_tdata[24];
   assign sprite_busy = req_tdata[25];

   // ---- handshake ----
   logic rsp_valid_ff;
   logic req_accept, step_go;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   // A sprite hold consumes the beat but freezes the fetcher.
   assign step_go    = req_accept && !sprite_busy;

   // ---- fetcher state ----
   fetch_step_type   step_ff, step_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [15:0]      daddr_ff, daddr_in;
   logic [7:0]       pat_lo_ff, pat_lo_in, pat_hi_ff, pat_hi_in;
   logic             pending_ff, pending_in;

   // Next step
   always_comb begin
      step_in = step_ff;
      if (step_go) begin
         unique case (step_ff)
            STEP_MAP:  step_in = STEP_LOW;
            STEP_LOW:  step_in = STEP_HIGH;
            STEP_HIGH: step_in = STEP_PUSH;
            STEP_PUSH: if (fifo_empty) step_in = STEP_MAP;
         endcase
      end
   end

   // ---- address arithmetic ----
   logic             enabled, use_win;
   logic [7:0]       bg_line;
   logic [4:0]       map_x;
   logic [9:0]       map_off;
   logic [15:0]      map_addr;
   logic [7:0]       tile_num;
   logic [2:0]       tile_row;
   logic [15:0]      pat_base, pat_addr;
   logic [COL_W:0]   col_next;
   logic             last_tile;
   logic [15:0]      row_bits;

   assign enabled  = lcd_control_ff[LCDC_BG_EN];
   assign use_win  = lcd_control_ff[LCDC_WIN_EN] && (line_y >= window_y_ff);
   assign bg_line  = line_y + scroll_y_ff;
   assign map_x    = scroll_x_ff[7:3] + col_ff;
   assign map_off  = use_win ? {window_line[7:3], col_ff} : {bg_line[7:3], map_x};
   // Map bases have their low ten bits clear, so the offset ORs in.
   assign map_addr = (use_win ? (lcd_control_ff[LCDC_WIN_MAP] ? MAP_HI_BASE : MAP_LO_BASE)
                              : (lcd_control_ff[LCDC_BG_MAP]  ? MAP_HI_BASE : MAP_LO_BASE))
                     | {6'd0, map_off};

   // Tile number arrives with this beat if the map read was issued.
   assign tile_num = pending_ff ? vram_byte : daddr_ff[7:0];
   assign tile_row = use_win ? window_line[2:0] : bg_line[2:0];
   // Signed addressing: tiles 0..127 from 0x9000, 128..255 wrap into 0x8800.
   assign pat_base = (lcd_control_ff[LCDC_DATA_SEL] || tile_num[7]) ? DATA_U_BASE
                                                                    : DATA_S_BASE;
   assign pat_addr = pat_base + {4'd0, tile_num, 4'd0} + {12'd0, tile_row, 1'b0};

   assign col_next  = {1'b0, col_ff} + (COL_W+1)'(1);
   assign last_tile = col_next >= (COL_W+1)'(TILES_PER_LINE);

   // Leftmost pixel (bit 7 of each plane) lands in the top bits.
   always_comb begin
      for (int b = 0; b < 8; b++) begin
         row_bits[2*b +: 2] = {pat_hi_in[b], pat_lo_in[b]};
      end
   end

   // ---- step outputs and datapath updates ----
   logic        rd_valid_in, push_in, done_in;
   logic [15:0] rd_addr_in;

   always_comb begin
      col_in      = col_ff;
      daddr_in    = daddr_ff;
      pat_lo_in   = pat_lo_ff;
      pat_hi_in   = pat_hi_ff;
      pending_in  = pending_ff;
      rd_valid_in = 1'b0;
      rd_addr_in  = '0;
      push_in     = 1'b0;
      done_in     = 1'b0;
      if (step_go) begin
         unique case (step_ff)
            STEP_MAP: begin
               if (enabled) begin
                  rd_valid_in = 1'b1;
                  rd_addr_in  = map_addr;
               end
            end
            STEP_LOW: begin
               if (pending_ff) daddr_in = {8'd0, vram_byte};
               if (enabled) begin
                  daddr_in    = pat_addr;
                  rd_valid_in = 1'b1;
                  rd_addr_in  = pat_addr;
               end
            end
            STEP_HIGH: begin
               if (pending_ff) pat_lo_in = vram_byte;
               if (enabled) begin
                  rd_valid_in = 1'b1;
                  rd_addr_in  = daddr_ff + 16'd1;
               end
            end
            STEP_PUSH: begin
               if (pending_ff) pat_hi_in = vram_byte;
               if (fifo_empty) begin
                  push_in = 1'b1;
                  done_in = last_tile;
                  col_in  = last_tile ? '0 : col_next[COL_W-1:0];
               end
            end
         endcase
         pending_in = rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff    <= STEP_MAP;
         col_ff     <= '0;
         daddr_ff   <= '0;
         pat_lo_ff  <= '0;
         pat_hi_ff  <= '0;
         pending_ff <= 1'b0;
      end else begin
         step_ff    <= step_in;
         col_ff     <= col_in;
         daddr_ff   <= daddr_in;
         pat_lo_ff  <= pat_lo_in;
         pat_hi_ff  <= pat_hi_in;
         pending_ff <= pending_in;
      end
   end

   // ---- result register ----
   logic [15:0] rsp_addr_ff, rsp_row_ff;
   logic [7:0]  rsp_pal_ff;
   logic        rsp_rd_ff, rsp_push_ff, rsp_done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Payload: load on every accepted beat; held beats yield an all-zero result.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_rd_ff   <= rd_valid_in;
         rsp_addr_ff <= rd_addr_in;
         rsp_push_ff <= push_in;
         rsp_row_ff  <= push_in ? row_bits : 16'd0;
         rsp_pal_ff  <= push_in ? bg_palette_ff : 8'd0;
         rsp_done_ff <= done_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_pal_ff, rsp_row_ff, rsp_addr_ff};
   assign rsp_tuser  = {rsp_push_ff, rsp_rd_ff};
   assign rsp_tlast  = rsp_done_ff;

endmodule

FILE: rtl/core/btf_checker.sv
// ----------------------------------------------------------------------------
// btf_checker
// Port-level checks of the background tile fetcher, bound to the top level.
// ----------------------------------------------------------------------------
module btf_checker
   import btf_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [RSP_USER_W-1:0] rsp_tuser,
   input logic                  rsp_tlast,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready
);

   // A stalled result beat holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp beat changed while stalled");

   // A step never both reads and pushes.
   a_rd_push_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("read and push in one beat");

   // The read address is zero unless a read is requested.
   a_rd_addr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[15:0] == 16'd0)
      else $error("read address set without read");

   // Pixels, palette and line end appear only with a push.
   a_no_push_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[1] |-> rsp_tdata[39:16] == 24'd0 && !rsp_tlast)
      else $error("pixel fields set without push");

endmodule

bind background_tile_fetcher btf_checker u_btf_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
